// File: rtl/avr_pkg.sv
// ----------------------------------------------------------------------------
// avr_pkg
// shared types, constants and the arctangent table of the vector rotation core
// ----------------------------------------------------------------------------
`default_nettype none

package avr_pkg;

  // cordic iteration count, capped at the size of the arctangent table
  localparam int CORDIC_STAGES = 16;
  localparam int MAX_TABLE     = 30;
  localparam int CORDIC_N      = (CORDIC_STAGES > MAX_TABLE) ? MAX_TABLE : CORDIC_STAGES;
  localparam int STAGE_IDX_W   = 5;

  // coordinate, cordic and trig widths
  localparam int COORD_W = 32;
  localparam int ANGLE_W = 16;
  localparam int CW      = 34;   // cordic x / y, q2.30 with headroom
  localparam int ZW      = 33;   // residual angle, 2^32 per turn
  localparam int TW      = 32;   // clamped cos / sin, q2.30

  localparam logic signed [CW-1:0] INV_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q30      = 34'sd1073741824;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_e;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef struct packed {
    axis_e                     op;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } avr_item_t;

  typedef struct packed {
    avr_item_t             item;
    quad_e                 quad;
    logic signed [CW-1:0]  cx;
    logic signed [CW-1:0]  cy;
    logic signed [ZW-1:0]  cz;
  } avr_cordic_t;

  typedef struct packed {
    avr_item_t            item;
    logic signed [TW-1:0] cos_v;
    logic signed [TW-1:0] sin_v;
  } avr_trig_t;

  // round(atan(2^-i) * 2^32 / (2*pi))
  function automatic logic [31:0] atan_entry(input logic [STAGE_IDX_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      5'd24:   v = 32'd41;
      5'd25:   v = 32'd20;
      5'd26:   v = 32'd10;
      5'd27:   v = 32'd5;
      5'd28:   v = 32'd3;
      5'd29:   v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/avr_cordic_stage.sv
// ----------------------------------------------------------------------------
// avr_cordic_stage
// one registered rotation-mode cordic iteration with valid / ready
// ----------------------------------------------------------------------------
`default_nettype none

module avr_cordic_stage import avr_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [STAGE_IDX_W-1:0] stage_idx_i,
  input  wire logic                   valid_i,
  output logic                        ready_o,
  input  wire avr_cordic_t            data_i,
  output logic                        valid_o,
  input  wire logic                   ready_i,
  output avr_cordic_t                 data_o
);

  logic                 valid_q;
  avr_cordic_t          data_q;
  avr_cordic_t          data_d;
  logic signed [CW-1:0] sx;
  logic signed [CW-1:0] sy;
  logic signed [ZW-1:0] at;

  always_comb begin
    sx = $signed(data_i.cx) >>> stage_idx_i;
    sy = $signed(data_i.cy) >>> stage_idx_i;
    at = $signed(ZW'(atan_entry(stage_idx_i)));
    data_d = data_i;
    if (!data_i.cz[ZW-1]) begin
      data_d.cx = data_i.cx - sy;
      data_d.cy = data_i.cy + sx;
      data_d.cz = data_i.cz - at;
    end else begin
      data_d.cx = data_i.cx + sy;
      data_d.cy = data_i.cy - sx;
      data_d.cz = data_i.cz + at;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: rtl/avr_quad.sv
// ----------------------------------------------------------------------------
// avr_quad
// quadrant fold of the cordic result and clamp of cos / sin to one
// ----------------------------------------------------------------------------
`default_nettype none

module avr_quad import avr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire avr_cordic_t data_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output avr_trig_t        data_o
);

  logic                 valid_q;
  avr_trig_t            data_q;
  avr_trig_t            data_d;
  logic signed [CW-1:0] c_raw;
  logic signed [CW-1:0] s_raw;

  function automatic logic signed [TW-1:0] clamp_one(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > ONE_Q30) begin
      r = ONE_Q30;
    end else if (v < -ONE_Q30) begin
      r = -ONE_Q30;
    end else begin
      r = v;
    end
    return r[TW-1:0];
  endfunction

  always_comb begin
    unique case (data_i.quad)
      QUAD_0: begin
        c_raw = data_i.cx;
        s_raw = data_i.cy;
      end
      QUAD_1: begin
        c_raw = -data_i.cy;
        s_raw = data_i.cx;
      end
      QUAD_2: begin
        c_raw = -data_i.cx;
        s_raw = -data_i.cy;
      end
      default: begin
        c_raw = data_i.cy;
        s_raw = -data_i.cx;
      end
    endcase
    data_d.item  = data_i.item;
    data_d.cos_v = clamp_one(c_raw);
    data_d.sin_v = clamp_one(s_raw);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: rtl/avr_mix.sv
// ----------------------------------------------------------------------------
// avr_mix
// product stage and round / saturate stage of the pair rotation
// ----------------------------------------------------------------------------
`default_nettype none

module avr_mix import avr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire avr_trig_t         data_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output logic [COORD_W-1:0]     out_x_o,
  output logic [COORD_W-1:0]     out_y_o,
  output logic [COORD_W-1:0]     out_z_o
);

  localparam int PW = 2 * COORD_W;

  typedef struct packed {
    avr_item_t            item;
    logic signed [PW-1:0] p_ac;
    logic signed [PW-1:0] p_bs;
    logic signed [PW-1:0] p_as;
    logic signed [PW-1:0] p_bc;
  } prod_t;

  logic                      prod_valid_q;
  logic                      prod_ready;
  prod_t                     prod_q;
  prod_t                     prod_d;
  logic signed [COORD_W-1:0] a_sel;
  logic signed [COORD_W-1:0] b_sel;

  logic                      out_valid_q;
  logic [COORD_W-1:0]        out_x_q;
  logic [COORD_W-1:0]        out_y_q;
  logic [COORD_W-1:0]        out_z_q;
  logic [COORD_W-1:0]        out_x_d;
  logic [COORD_W-1:0]        out_y_d;
  logic [COORD_W-1:0]        out_z_d;
  logic [COORD_W-1:0]        a_rot;
  logic [COORD_W-1:0]        b_rot;

  // sum or difference of two products plus half an lsb, floor by 2^30, then saturate
  function automatic logic [COORD_W-1:0] round_sat(input logic signed [PW-1:0] p,
                                                  input logic signed [PW-1:0] q,
                                                  input logic                 sub);
    logic signed [PW:0]     sum;
    logic signed [PW-30:0]  v;
    logic [COORD_W-1:0]     r;
    if (sub) begin
      sum = {p[PW-1], p} - {q[PW-1], q} + (PW+1)'(1 << 29);
    end else begin
      sum = {p[PW-1], p} + {q[PW-1], q} + (PW+1)'(1 << 29);
    end
    v = sum[PW:30];
    if (v[PW-30:COORD_W-1] == '0 || v[PW-30:COORD_W-1] == '1) begin
      r = v[COORD_W-1:0];
    end else if (v[PW-30]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

  // pair (a,b): (y,z) for x, (z,x) for y, (x,y) for z
  always_comb begin
    case (data_i.item.op)
      AXIS_X: begin
        a_sel = data_i.item.y;
        b_sel = data_i.item.z;
      end
      AXIS_Y: begin
        a_sel = data_i.item.z;
        b_sel = data_i.item.x;
      end
      default: begin
        a_sel = data_i.item.x;
        b_sel = data_i.item.y;
      end
    endcase
    prod_d.item = data_i.item;
    prod_d.p_ac = a_sel * data_i.cos_v;
    prod_d.p_bs = b_sel * data_i.sin_v;
    prod_d.p_as = a_sel * data_i.sin_v;
    prod_d.p_bc = b_sel * data_i.cos_v;
  end

  assign prod_ready = !out_valid_q || ready_i;
  assign ready_o    = !prod_valid_q || prod_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else if (ready_o) begin
      prod_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    a_rot   = round_sat(prod_q.p_ac, prod_q.p_bs, 1'b1);
    b_rot   = round_sat(prod_q.p_as, prod_q.p_bc, 1'b0);
    out_x_d = prod_q.item.x;
    out_y_d = prod_q.item.y;
    out_z_d = prod_q.item.z;
    case (prod_q.item.op)
      AXIS_X: begin
        out_y_d = a_rot;
        out_z_d = b_rot;
      end
      AXIS_Y: begin
        out_z_d = a_rot;
        out_x_d = b_rot;
      end
      AXIS_Z: begin
        out_x_d = a_rot;
        out_y_d = b_rot;
      end
      default: begin
        out_x_d = prod_q.item.x;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (prod_ready) begin
      out_valid_q <= prod_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_ready && prod_valid_q) begin
      out_x_q <= out_x_d;
      out_y_q <= out_y_d;
      out_z_q <= out_z_d;
    end
  end

  assign valid_o = out_valid_q;
  assign out_x_o = out_x_q;
  assign out_y_o = out_y_q;
  assign out_z_o = out_z_q;

endmodule

`default_nettype wire

// File: rtl/axis_vector_rotation_core.sv
// path: input register, CORDIC_STAGES cordic registers, quadrant, product, output
// throughput: one transaction per cycle when not stalled; every stage is a register
// with its own valid and a stalled stage only holds back the stages behind it
// reset: rst_ni clears all valid bits asynchronously, payload registers are not reset
// ----------------------------------------------------------------------------
// axis_vector_rotation_core
// rotates a q16.16 vector about the x, y or z axis by a 16-bit binary angle
// using a pipelined gain-compensated cordic and a saturating pair rotation
// ----------------------------------------------------------------------------
`default_nettype none

module axis_vector_rotation_core import avr_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // slave side
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [111:0] s_axis_tdata,   // in_x[31:0], in_y[63:32], in_z[95:64],
                                            // angle[111:96]
  input  wire logic [1:0]   s_axis_tuser,   // op[1:0]: rotation axis
  // master side
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [95:0]       m_axis_tdata    // out_x[31:0], out_y[63:32], out_z[95:64]
);

  // stage 0 is the input register, stages 1..CORDIC_N are cordic iterations
  logic        cord_valid [0:CORDIC_N];
  logic        cord_ready [0:CORDIC_N];
  avr_cordic_t cord_data  [0:CORDIC_N];

  avr_cordic_t             in_d;
  avr_cordic_t             in_q;
  logic                    in_valid_q;
  logic [ANGLE_W-1:0]      angle;
  logic [ANGLE_W-1:0]      angle_rnd;
  logic [ANGLE_W-1:0]      resid;

  logic                    trig_valid;
  logic                    trig_ready;
  avr_trig_t               trig_data;
  logic                    mix_ready;

  logic [COORD_W-1:0]      out_x;
  logic [COORD_W-1:0]      out_y;
  logic [COORD_W-1:0]      out_z;

  // angle split: nearest quadrant and a signed residual within +/- 1/8 turn
  always_comb begin
    angle        = s_axis_tdata[111:96];
    angle_rnd    = angle + 16'h2000;
    in_d.quad    = quad_e'(angle_rnd[15:14]);
    resid        = angle - {angle_rnd[15:14], 14'b0};
    in_d.item.op = axis_e'(s_axis_tuser);
    in_d.item.x  = s_axis_tdata[31:0];
    in_d.item.y  = s_axis_tdata[63:32];
    in_d.item.z  = s_axis_tdata[95:64];
    in_d.cx      = INV_GAIN_Q30;        // prescaled by the inverse cordic gain
    in_d.cy      = '0;
    in_d.cz      = {resid[15], resid, 16'b0};
  end

  assign s_axis_tready = !in_valid_q || cord_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= in_d;
    end
  end

  assign cord_valid[0] = in_valid_q;
  assign cord_data[0]  = in_q;

  // cordic chain, one iteration per stage
  for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
    avr_cordic_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .stage_idx_i (STAGE_IDX_W'(i)),
      .valid_i     (cord_valid[i]),
      .ready_o     (cord_ready[i]),
      .data_i      (cord_data[i]),
      .valid_o     (cord_valid[i+1]),
      .ready_i     (cord_ready[i+1]),
      .data_o      (cord_data[i+1])
    );
  end

  assign cord_ready[CORDIC_N] = trig_ready;

  // quadrant fold and clamp
  avr_quad u_quad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cord_valid[CORDIC_N]),
    .ready_o (trig_ready),
    .data_i  (cord_data[CORDIC_N]),
    .valid_o (trig_valid),
    .ready_i (mix_ready),
    .data_o  (trig_data)
  );

  // products, rounding, saturation; its last register drives the master side
  avr_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (trig_valid),
    .ready_o (mix_ready),
    .data_i  (trig_data),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .out_x_o (out_x),
    .out_y_o (out_y),
    .out_z_o (out_z)
  );

  assign m_axis_tdata = {out_z, out_y, out_x};

  // an empty output register leaves room all the way back to the input
  a_ready_when_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input not ready while the output register is empty");

  // a stalled cordic result is held, not dropped
  a_cordic_tail_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cord_valid[CORDIC_N] && !trig_ready |=> cord_valid[CORDIC_N])
    else $error("last cordic stage lost its transaction under stall");

  // a stalled trig result is held, not dropped
  a_trig_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    trig_valid && !mix_ready |=> trig_valid && $stable(trig_data))
    else $error("trig stage changed under stall");

endmodule

`default_nettype wire

// File: test/axis_vector_rotation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_vector_rotation_checker
// watches both stream channels of the rotation core, computes the rotated
// vector of every accepted input transaction and compares it with the output
// ----------------------------------------------------------------------------

module axis_vector_rotation_checker import avr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,   // in_x[31:0], in_y[63:32], in_z[95:64], angle[111:96]
  input  logic [1:0]   s_axis_tuser,   // op[1:0]
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [95:0]  m_axis_tdata,   // out_x[31:0], out_y[63:32], out_z[95:64]
  output int           fail_count_o,
  output int           pending_o
);

  localparam int     MAX_STAGES = 30;
  localparam int     N_STAGES   = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
  localparam longint UNIT_Q30   = 64'sd1073741824;
  localparam longint INV_GAIN   = 64'sd652032874;

  // atan(2^-i) in binary angle units, 2^32 per turn
  localparam longint ATAN_TURN [MAX_STAGES] = '{
    536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087,
    667544, 333772, 166886, 83443, 41722,
    20861, 10430, 5215, 2608, 1304,
    652, 326, 163, 81, 41,
    20, 10, 5, 3, 1
  };

  logic [95:0] rotated_q [$];
  int          fail_cnt    = 0;
  int          outstanding = 0;

  assign fail_count_o = fail_cnt;
  assign pending_o    = outstanding;

  function automatic longint clamp_unit(input longint v);
    if (v > UNIT_Q30) return UNIT_Q30;
    if (v < -UNIT_Q30) return -UNIT_Q30;
    return v;
  endfunction

  // a*ka + b*kb in q2.30 weights, rounded half up to q16.16 and saturated
  function automatic logic [31:0] rotate_pair(input logic signed [31:0] a, input longint ka,
                                              input logic signed [31:0] b, input longint kb);
    longint acc;
    acc = (longint'(a) * ka + longint'(b) * kb + (longint'(1) <<< 29)) >>> 30;
    if (acc > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (acc < -64'sd2147483648) return 32'h8000_0000;
    return acc[31:0];
  endfunction

  function automatic logic [95:0] rotate_vector(input axis_e axis, input logic [95:0] xyz,
                                                input logic [15:0] angle);
    logic [15:0]        biased;
    logic [15:0]        resid;
    quad_e              quad;
    longint             zr, cx, cy, cx_next, cos_v, sin_v;
    logic signed [31:0] x, y, z;
    logic [31:0]        rx, ry, rz;
    x  = xyz[31:0];
    y  = xyz[63:32];
    z  = xyz[95:64];
    rx = x;
    ry = y;
    rz = z;
    // nearest quadrant, residual within plus or minus an eighth of a turn
    biased = angle + 16'h2000;
    quad   = quad_e'(biased[15:14]);
    resid  = angle - {biased[15:14], 14'd0};
    zr     = longint'($signed(resid)) * 65536;
    cx     = INV_GAIN;
    cy     = 0;
    for (int i = 0; i < N_STAGES; i++) begin
      if (zr >= 0) begin
        cx_next = cx - (cy >>> i);
        cy      = cy + (cx >>> i);
        zr      = zr - ATAN_TURN[i];
      end else begin
        cx_next = cx + (cy >>> i);
        cy      = cy - (cx >>> i);
        zr      = zr + ATAN_TURN[i];
      end
      cx = cx_next;
    end
    case (quad)
      QUAD_0: begin cos_v = cx;  sin_v = cy;  end
      QUAD_1: begin cos_v = -cy; sin_v = cx;  end
      QUAD_2: begin cos_v = -cx; sin_v = -cy; end
      QUAD_3: begin cos_v = cy;  sin_v = -cx; end
    endcase
    cos_v = clamp_unit(cos_v);
    sin_v = clamp_unit(sin_v);
    case (axis)
      AXIS_X: begin
        ry = rotate_pair(y, cos_v, z, -sin_v);
        rz = rotate_pair(y, sin_v, z, cos_v);
      end
      AXIS_Y: begin
        rz = rotate_pair(z, cos_v, x, -sin_v);
        rx = rotate_pair(z, sin_v, x, cos_v);
      end
      AXIS_Z: begin
        rx = rotate_pair(x, cos_v, y, -sin_v);
        ry = rotate_pair(x, sin_v, y, cos_v);
      end
      AXIS_NONE: ;
    endcase
    return {rz, ry, rx};
  endfunction

  always @(posedge clk_i) begin
    logic [95:0] want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (rotated_q.size() == 0) begin
          $display("%0t: unexpected output transaction, expected none, actual %h",
                   $time, m_axis_tdata);
          fail_cnt++;
        end else begin
          want = rotated_q.pop_front();
          for (int i = 0; i < 3; i++) begin
            if (m_axis_tdata[32*i +: 32] !== want[32*i +: 32]) begin
              $display("%0t: %s mismatch, expected %0d, actual %0d", $time,
                       (i == 0) ? "out_x" : (i == 1) ? "out_y" : "out_z",
                       $signed(want[32*i +: 32]), $signed(m_axis_tdata[32*i +: 32]));
              fail_cnt++;
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        rotated_q.push_back(rotate_vector(axis_e'(s_axis_tuser), s_axis_tdata[95:0],
                                          s_axis_tdata[111:96]));
      outstanding <= rotated_q.size();
    end
  end

endmodule

// File: test/tb_axis_vector_rotation_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_axis_vector_rotation_core
// drives directed and random vectors into the rotation core under varying
// back pressure and source gaps; a separate checker predicts and compares
// ----------------------------------------------------------------------------

module tb_axis_vector_rotation_core import avr_pkg::*;;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 10;
  // pipeline depth of the core's registers, used for the quiet tail at the end
  localparam int LATENCY        = CORDIC_N + 4;
  localparam int TAIL_CYCLES    = 4 * LATENCY;
  // long enough that the core fills up completely and stalls its input
  localparam int SINK_HOLD_CYCLES = 300;
  localparam int TIMEOUT_CYCLES   = 200_000;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata;    // in_x[31:0], in_y[63:32], in_z[95:64], angle[111:96]
  logic [1:0]   s_axis_tuser;    // op[1:0]: rotation axis
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;    // out_x[31:0], out_y[63:32], out_z[95:64]

  int   fail_count;
  int   pending;
  int   src_idle_pct;
  int   sink_idle_pct;
  logic hold_req;
  int   hold_cnt = 0;

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  axis_vector_rotation_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  axis_vector_rotation_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // receiver: random back pressure, plus one long hold-off once requested;
  // the hold-off is counted here so it runs regardless of what the sender does
  always @(posedge clk_i) begin
    if (hold_req && hold_cnt < SINK_HOLD_CYCLES) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= hold_cnt + 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // offer one vector, with random idle cycles first; returns at the edge where
  // the transaction is taken, leaving tvalid high so back-to-back items need
  // no extra nonblocking assignment in that step
  task automatic send_vec(input axis_e op, input logic [31:0] x, input logic [31:0] y,
                          input logic [31:0] z, input logic [15:0] ang);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ang, z, y, x};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // coordinates: extremes, small q16.16 values near one, spread magnitudes,
  // and plain random words so every bit toggles
  function automatic logic [31:0] rand_coord();
    logic [31:0] mag;
    mag = $urandom >> $urandom_range(31);
    case ($urandom_range(7))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return 32'($urandom_range(262143)) - 32'd131072;
      3:       return $urandom_range(1) ? mag : -mag;
      default: return $urandom;
    endcase
  endfunction

  // angles: a quarter of them right at an octant edge, where the quadrant
  // choice or the sign of the residual flips, the rest uniform
  function automatic logic [15:0] rand_angle();
    if ($urandom_range(3) == 0)
      return 16'(($urandom_range(7) << 13) + $urandom_range(2) - 1);
    return 16'($urandom);
  endfunction

  task automatic send_random(input int count);
    axis_e op;
    repeat (count) begin
      op = ($urandom_range(7) == 0) ? AXIS_NONE : axis_e'($urandom_range(2));
      send_vec(op, rand_coord(), rand_coord(), rand_coord(), rand_angle());
    end
  endtask

  // stop offering and wait until every predicted result has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = AXIS_X;
    hold_req      = 1'b0;
    src_idle_pct  = 35;
    sink_idle_pct = 57;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: the four quadrant angles and the full-turn wrap
    send_vec(AXIS_Z, Q_ONE, 32'd0, 32'd0, 16'h0000);
    send_vec(AXIS_Z, Q_ONE, 32'd0, 32'd0, 16'h4000);
    send_vec(AXIS_Z, Q_ONE, 32'd0, 32'd0, 16'h8000);
    send_vec(AXIS_Z, Q_ONE, 32'd0, 32'd0, 16'hC000);
    send_vec(AXIS_Z, Q_ONE, 32'h0002_0000, 32'd0, 16'hFFFF);
    // octant edges, where the residual changes sign
    send_vec(AXIS_X, 32'h0001_2345, Q_ONE, -32'sd196608, 16'h2000);
    send_vec(AXIS_X, 32'h0001_2345, Q_ONE, -32'sd196608, 16'h1FFF);
    send_vec(AXIS_Y, 32'h0003_0000, -32'sd65536, Q_ONE, 16'h6000);
    send_vec(AXIS_Y, 32'h0003_0000, -32'sd65536, Q_ONE, 16'h5FFF);
    send_vec(AXIS_Y, 32'd0, Q_ONE, 32'h0000_8000, 16'hA000);
    // unused selector passes the vector through
    send_vec(AXIS_NONE, 32'd7, -32'sd8, 32'd9, 16'h1234);
    send_vec(AXIS_NONE, Q_MIN, Q_MAX, 32'hFFFF_FFFF, 16'hFFFF);
    // overflow: rotated length exceeds the q16.16 range and saturates
    send_vec(AXIS_Z, Q_MAX, Q_MAX, 32'd0, 16'h2000);
    send_vec(AXIS_Z, Q_MIN, Q_MIN, 32'd0, 16'h2000);
    send_vec(AXIS_X, 32'd0, Q_MAX, Q_MIN, 16'hE000);
    send_vec(AXIS_Y, Q_MIN, 32'd0, Q_MAX, 16'h6000);
    send_vec(AXIS_Z, Q_MIN, 32'd0, 32'd0, 16'h8000);
    // smallest steps and rounding of tiny values
    send_vec(AXIS_X, 32'd0, 32'hFFFF_FFFF, 32'd1, 16'h0001);
    send_vec(AXIS_Y, 32'd1, 32'd0, 32'hFFFF_FFFF, 16'h8000);
    send_vec(AXIS_Z, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF);
    send_vec(AXIS_X, Q_MAX, Q_MAX, Q_MAX, 16'h4000);

    // phase 1: sender idles 35 percent, receiver 57 percent
    send_random(80);
    // receiver holds off for a long stretch while the sender keeps offering,
    // so the pipeline fills up and input backs up
    src_idle_pct = 0;
    hold_req    <= 1'b1;
    send_random(60);
    src_idle_pct = 35;
    send_random(100);
    wait_drained();

    // phase 2: roles swapped
    src_idle_pct  = 57;
    sink_idle_pct = 35;
    send_random(250);
    wait_drained();

    // phase 3: full rate on both sides
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    send_random(250);
    wait_drained();

    // quiet tail to catch any spurious output transaction
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Some tests failed");
    $finish;
  end

endmodule
